@@ design/kwve_pkg.sv @@
package kwve_pkg;

    // Table sizes.
    localparam int MAX_ROWS    = 1024;
    localparam int MAX_ATTRS   = 8;
    localparam int MAX_K       = 16;
    // Query jobs waiting between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Derived widths.
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int ATTR_W  = $clog2(MAX_ATTRS);
    localparam int POS_W   = $clog2(MAX_ATTRS + 1);
    localparam int K_W     = $clog2(MAX_K + 1);
    localparam int SLOT_W  = $clog2(MAX_K);
    localparam int FADDR_W = ROW_W + ATTR_W;

    // Field widths.
    localparam int FEAT_W  = 24;
    localparam int VAL_W   = 32;
    localparam int DIST_W  = 32;
    localparam int ABS_W   = FEAT_W;
    localparam int SUM_W   = 2 * ABS_W + ATTR_W + 1;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int DIV_W   = 64;
    localparam int DVS_W   = DIST_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_K     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTRS = 2'd2;

    localparam logic [K_W-1:0]   K_RESET     = K_W'(3);
    localparam logic [POS_W-1:0] ATTRS_RESET = POS_W'(1);

    localparam logic signed [VAL_W-1:0] EST_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] EST_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_TRAIN = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    // One query waiting for the scan: its attributes and the settings in force.
    typedef struct packed {
        logic [MAX_ATTRS-1:0][FEAT_W-1:0] query;
        logic [CNT_W-1:0]                 rows;
        logic [K_W-1:0]                   k;
        logic [POS_W-1:0]                 attrs;
        logic                             mode;
    } t_job;

endpackage

@@ design/kwve_if.sv @@
interface kwve_in_if;
    import kwve_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [FEAT_W-1:0] attr_value;
    logic signed [VAL_W-1:0]  known_value;
    logic                     row_last;

    modport source(output valid, req_type, attr_value, known_value, row_last, input ready);
    modport sink(input valid, req_type, attr_value, known_value, row_last, output ready);
endinterface

interface kwve_out_if;
    import kwve_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] estimate;
    logic [1:0]              status;
    logic [CNT_W-1:0]        stored_rows;

    modport source(output valid, estimate, status, stored_rows, input ready);
    modport sink(input valid, estimate, status, stored_rows, output ready);
endinterface

@@ design/kwve_ram.sv @@
module kwve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/kwve_div.sv @@
module kwve_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [kwve_pkg::DIV_W-1:0]        i_dividend,
    input  logic [kwve_pkg::DVS_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic [kwve_pkg::DIV_W-1:0]        o_quotient
);
    import kwve_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DIV_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   shifted;
    logic             fits;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= DVS_W'(shifted - {1'b0, r_dvs});
                end else begin
                    r_rem <= shifted[DVS_W-1:0];
                end
                r_quo <= {r_quo[DIV_W-2:0], fits};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

@@ design/kwve_sqrt.sv @@
module kwve_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kwve_pkg::SUM_W-1:0]  i_radicand,
    output logic                        o_done,
    output logic [kwve_pkg::ROOT_W-1:0] o_root
);
    import kwve_pkg::*;

    localparam int CW = $clog2(ROOT_W + 1);

    logic [SUM_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              fits;

    // Digit-by-digit square root, two radicand bits per cycle.
    assign rem_sh = {r_rem, r_rad[SUM_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= (ROOT_W+2)'(rem_sh - trial);
                end else begin
                    r_rem <= rem_sh[ROOT_W+1:0];
                end
                r_root <= {r_root[ROOT_W-2:0], fits};
                r_rad  <= {r_rad[SUM_W-3:0], 2'b00};
                r_cnt  <= r_cnt + CW'(1);
                if (r_cnt == CW'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ design/kwve_front.sv @@
module kwve_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kwve_in_if.sink                          i_req_ch,
    input  logic                             i_cfg_we,
    input  logic [kwve_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kwve_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_feat_we,
    output logic [kwve_pkg::FADDR_W-1:0]     o_feat_waddr,
    output logic [kwve_pkg::FEAT_W-1:0]      o_feat_wdata,
    output logic                             o_val_we,
    output logic [kwve_pkg::ROW_W-1:0]       o_val_waddr,
    output logic [kwve_pkg::VAL_W-1:0]       o_val_wdata,
    output logic                             o_job_valid,
    output kwve_pkg::t_job                   o_job,
    input  logic                             i_job_pop,
    input  logic                             i_back_idle
);
    import kwve_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    logic [K_W-1:0]          r_k;
    logic                    r_mode;
    logic [POS_W-1:0]        r_attrs;
    logic [CNT_W-1:0]        r_row_cnt;
    logic [POS_W-1:0]        r_pos;
    logic                    r_filling;
    logic [POS_W-1:0]        r_fill_pos;
    logic [FEAT_W-1:0]       r_query [MAX_ATTRS];
    t_job                    r_q [QUEUE_DEPTH];
    logic [QP_W-1:0]         r_wp;
    logic [QP_W-1:0]         r_rp;
    logic [QC_W-1:0]         r_qcnt;

    t_req                    req;
    logic                    room;
    logic                    has_slot;
    logic                    q_full;
    logic                    q_empty;
    logic                    accept;
    logic                    push;
    logic [POS_W-1:0]        pos_next;
    logic [FEAT_W-1:0]       n_query [MAX_ATTRS];
    t_job                    new_job;

    assign req      = t_req'(i_req_ch.req_type);
    assign room     = r_row_cnt < CNT_W'(MAX_ROWS);
    assign has_slot = r_pos < POS_W'(MAX_ATTRS);
    assign pos_next = has_slot ? r_pos + POS_W'(1) : r_pos;
    assign q_full   = r_qcnt == QC_W'(QUEUE_DEPTH);
    assign q_empty  = r_qcnt == '0;

    // Hold off during a zero fill, a clear while a scan may still read the
    // table, and a query row end when no queue entry is free.
    assign i_req_ch.ready = !r_filling
        && !(req == REQ_CLEAR && (!i_back_idle || !q_empty))
        && !(req == REQ_QUERY && i_req_ch.row_last && q_full);
    assign accept = i_req_ch.valid && i_req_ch.ready;
    assign push   = accept && req == REQ_QUERY && i_req_ch.row_last;

    // Feature table writes: attribute items, then zeros up to the row width.
    always_comb begin
        if (r_filling) begin
            o_feat_we    = 1'b1;
            o_feat_waddr = {r_row_cnt[ROW_W-1:0], r_fill_pos[ATTR_W-1:0]};
            o_feat_wdata = '0;
        end else begin
            o_feat_we    = accept && req == REQ_TRAIN && has_slot && room;
            o_feat_waddr = {r_row_cnt[ROW_W-1:0], r_pos[ATTR_W-1:0]};
            o_feat_wdata = i_req_ch.attr_value;
        end
    end

    assign o_val_we    = accept && req == REQ_TRAIN && i_req_ch.row_last && room;
    assign o_val_waddr = r_row_cnt[ROW_W-1:0];
    assign o_val_wdata = i_req_ch.known_value;

    // Query buffer after this item, and the job built at a query row end.
    always_comb begin
        for (int i = 0; i < MAX_ATTRS; i++) begin
            if (has_slot && r_pos == POS_W'(i)) begin
                n_query[i] = i_req_ch.attr_value;
            end else begin
                n_query[i] = r_query[i];
            end
            new_job.query[i] = (POS_W'(i) < pos_next) ? n_query[i] : '0;
        end
        new_job.rows  = r_row_cnt;
        if (r_k == '0) begin
            new_job.k = K_W'(1);
        end else if (r_k > K_W'(MAX_K)) begin
            new_job.k = K_W'(MAX_K);
        end else begin
            new_job.k = r_k;
        end
        if (r_attrs == '0) begin
            new_job.attrs = POS_W'(1);
        end else if (r_attrs > POS_W'(MAX_ATTRS)) begin
            new_job.attrs = POS_W'(MAX_ATTRS);
        end else begin
            new_job.attrs = r_attrs;
        end
        new_job.mode = r_mode;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= K_RESET;
            r_mode  <= 1'b0;
            r_attrs <= ATTRS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_K:     r_k     <= i_cfg_data[K_W-1:0];
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_ATTRS: r_attrs <= i_cfg_data[POS_W-1:0];
                default:   ;
            endcase
        end
    end

    // Row bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= '0;
            r_pos      <= '0;
            r_filling  <= 1'b0;
            r_fill_pos <= '0;
        end else if (r_filling) begin
            r_fill_pos <= r_fill_pos + POS_W'(1);
            if (r_fill_pos == POS_W'(MAX_ATTRS - 1)) begin
                r_filling <= 1'b0;
                r_row_cnt <= r_row_cnt + CNT_W'(1);
            end
        end else if (accept) begin
            unique case (req) inside
                REQ_CLEAR: begin
                    r_row_cnt <= '0;
                    r_pos     <= '0;
                end
                REQ_TRAIN, REQ_QUERY: begin
                    if (i_req_ch.row_last) begin
                        r_pos <= '0;
                        if (req == REQ_TRAIN && room) begin
                            if (pos_next == POS_W'(MAX_ATTRS)) begin
                                r_row_cnt <= r_row_cnt + CNT_W'(1);
                            end else begin
                                r_filling  <= 1'b1;
                                r_fill_pos <= pos_next;
                            end
                        end
                    end else begin
                        r_pos <= pos_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // Query attribute buffer; a query row end leaves the unused slots zeroed.
    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int i = 0; i < MAX_ATTRS; i++) begin
                r_query[i] <= new_job.query[i];
            end
        end else if (accept && req == REQ_QUERY) begin
            r_query <= n_query;
        end
    end

    // Job queue toward the scan engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QP_W'(1);
            end
            if (i_job_pop) begin
                r_rp <= r_rp + QP_W'(1);
            end
            r_qcnt <= r_qcnt + QC_W'(push) - QC_W'(i_job_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= new_job;
        end
    end

    assign o_job_valid = !q_empty;
    assign o_job       = r_q[r_rp];
endmodule

@@ design/kwve_back.sv @@
module kwve_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  kwve_pkg::t_job               i_job,
    output logic                         o_job_pop,
    output logic                         o_idle,
    output logic [kwve_pkg::FADDR_W-1:0] o_feat_raddr,
    input  logic [kwve_pkg::FEAT_W-1:0]  i_feat_rdata,
    output logic [kwve_pkg::ROW_W-1:0]   o_val_raddr,
    input  logic [kwve_pkg::VAL_W-1:0]   i_val_rdata,
    kwve_out_if.source                   o_res_ch
);
    import kwve_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_SQRT,
        S_SEL,
        S_SWEEP,
        S_SUM,
        S_FDIV,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_job                    r_job;
    logic [CNT_W-1:0]        r_row;
    logic [POS_W-1:0]        r_issue;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic [ATTR_W-1:0]       r_idx1;
    logic [ABS_W-1:0]        r_abs;
    logic [2*ABS_W-1:0]      r_term;
    logic [SUM_W-1:0]        r_sum;
    logic [DIST_W-1:0]       r_dist;
    logic [K_W-1:0]          r_fill;
    logic [DIST_W-1:0]       r_far;
    logic [DIST_W-1:0]       r_max;
    logic [ROW_W-1:0]        r_nidx [MAX_K];
    logic [DIST_W-1:0]       r_ndist [MAX_K];
    logic [K_W-1:0]          r_slot;
    logic                    r_sv1;
    logic [DIST_W-1:0]       r_sdist1;
    logic                    r_pv;
    logic signed [DIV_W-1:0] r_prod;
    logic signed [DIV_W-1:0] r_svd;
    logic [DVS_W-1:0]        r_sd;
    logic                    r_neg;
    logic signed [VAL_W-1:0] r_res_est;
    t_status                 r_res_status;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_est;
    logic [1:0]              r_out_status;
    logic [CNT_W-1:0]        r_out_rows;

    logic [FEAT_W-1:0]           qv;
    logic signed [FEAT_W:0]      diff;
    logic [FEAT_W:0]             diff_mag;
    logic                        acc_done;
    logic                        sum_done;
    logic                        row_end;
    logic [SLOT_W-1:0]           rep_slot;
    logic                        rep_found;
    logic [DIST_W-1:0]           cur_dist;
    logic [DIST_W-1:0]           n_max;
    logic signed [VAL_W+DIST_W:0] prod_full;
    logic [DIV_W-1:0]            abs_svd;
    logic                        div_start;
    logic [DIV_W-1:0]            div_dividend;
    logic [DVS_W-1:0]            div_divisor;
    logic                        div_done;
    logic [DIV_W-1:0]            div_q;
    logic                        sqrt_start;
    logic                        sqrt_done;
    logic [ROOT_W-1:0]           sqrt_root;
    logic signed [VAL_W-1:0]     est_sat;

    // Attribute difference for the row being measured.
    assign o_feat_raddr = {r_row[ROW_W-1:0], r_issue[ATTR_W-1:0]};
    assign qv           = r_job.query[r_idx1];
    assign diff         = $signed({i_feat_rdata[FEAT_W-1], i_feat_rdata})
                        - $signed({qv[FEAT_W-1], qv});
    assign diff_mag     = diff[FEAT_W] ? (FEAT_W+1)'(0) - diff : diff;

    assign acc_done = r_issue == r_job.attrs && !r_v1 && !r_v2 && !r_v3;
    assign sum_done = r_slot == r_fill && !r_sv1 && !r_pv;
    assign row_end  = (r_row + CNT_W'(1)) == r_job.rows;

    // Lowest slot that holds the farthest kept distance.
    always_comb begin
        rep_slot  = '0;
        rep_found = 1'b0;
        for (int j = 0; j < MAX_K; j++) begin
            if (!rep_found && K_W'(j) < r_fill && r_ndist[j] == r_far) begin
                rep_slot  = SLOT_W'(j);
                rep_found = 1'b1;
            end
        end
    end

    // Slot reads for the farthest sweep and the weighted sums.
    assign cur_dist    = r_ndist[r_slot[SLOT_W-1:0]];
    assign n_max       = (r_slot == '0 || cur_dist > r_max) ? cur_dist : r_max;
    assign o_val_raddr = r_nidx[r_slot[SLOT_W-1:0]];
    assign prod_full   = $signed(i_val_rdata) * $signed({1'b0, r_sdist1});
    assign abs_svd     = r_svd[DIV_W-1] ? DIV_W'(0) - r_svd : r_svd;

    // The divider serves both the per-row mean and the final quotient.
    assign div_start = (r_state == S_ACC && acc_done)
                    || (r_state == S_SUM && sum_done && r_sd != '0);
    always_comb begin
        if (r_state == S_ACC) begin
            div_dividend = DIV_W'(r_sum);
            div_divisor  = DVS_W'(r_job.attrs);
        end else begin
            div_dividend = abs_svd;
            div_divisor  = r_sd;
        end
    end
    assign sqrt_start = r_state == S_DIV && div_done && !r_job.mode;

    // Truncated quotient with its sign, saturated to the result range.
    always_comb begin
        if (r_neg) begin
            if (div_q > DIV_W'(2) ** (VAL_W - 1)) begin
                est_sat = EST_MIN;
            end else begin
                est_sat = VAL_W'(0) - div_q[VAL_W-1:0];
            end
        end else if (div_q > DIV_W'(EST_MAX)) begin
            est_sat = EST_MAX;
        end else begin
            est_sat = div_q[VAL_W-1:0];
        end
    end

    kwve_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    kwve_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (div_q[SUM_W-1:0]),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign o_job_pop = r_state == S_IDLE && i_job_valid;
    assign o_idle    = r_state == S_IDLE;

    // Scan sequencer with its datapath and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_sv1       <= 1'b0;
            r_pv        <= 1'b0;
            r_fill      <= '0;
            r_row       <= '0;
            r_issue     <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res_ch.valid && o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            // Distance pipeline: read, difference, square (magnitude only in mode 1), accumulate.
            r_v1 <= 1'b0;
            if (r_state == S_ACC && r_issue != r_job.attrs) begin
                r_v1    <= 1'b1;
                r_idx1  <= r_issue[ATTR_W-1:0];
                r_issue <= r_issue + POS_W'(1);
            end
            r_v2 <= r_v1;
            if (r_v1) begin
                r_abs <= diff_mag[ABS_W-1:0];
            end
            r_v3 <= r_v2;
            if (r_v2) begin
                r_term <= r_job.mode ? (2*ABS_W)'(r_abs) : r_abs * r_abs;
            end
            if (r_v3) begin
                r_sum <= r_sum + SUM_W'(r_term);
            end

            // Weighted-sum pipeline: value read, product, accumulate.
            r_sv1 <= 1'b0;
            if (r_state == S_SUM && r_slot != r_fill) begin
                r_sv1    <= 1'b1;
                r_sdist1 <= cur_dist;
                r_slot   <= r_slot + K_W'(1);
            end
            r_pv <= r_sv1;
            if (r_sv1) begin
                r_prod <= prod_full[DIV_W-1:0];
                r_sd   <= r_sd + DVS_W'(r_sdist1);
            end
            if (r_pv) begin
                r_svd <= r_svd + r_prod;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_row   <= '0;
                        r_issue <= '0;
                        r_sum   <= '0;
                        r_fill  <= '0;
                        if (i_job.rows == '0) begin
                            r_res_est    <= '0;
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (acc_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_job.mode) begin
                            r_dist  <= div_q[DIST_W-1:0];
                            r_state <= S_SEL;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_dist  <= DIST_W'(sqrt_root);
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (r_fill < r_job.k || r_dist < r_far) begin
                        if (r_fill < r_job.k) begin
                            r_nidx[r_fill[SLOT_W-1:0]]  <= r_row[ROW_W-1:0];
                            r_ndist[r_fill[SLOT_W-1:0]] <= r_dist;
                            if (r_fill == '0 || r_dist > r_far) begin
                                r_far <= r_dist;
                            end
                            r_fill <= r_fill + K_W'(1);
                        end else begin
                            r_nidx[rep_slot]  <= r_row[ROW_W-1:0];
                            r_ndist[rep_slot] <= r_dist;
                        end
                    end
                    if (r_fill >= r_job.k && r_dist < r_far) begin
                        r_slot  <= '0;
                        r_state <= S_SWEEP;
                    end else if (row_end) begin
                        r_slot  <= '0;
                        r_svd   <= '0;
                        r_sd    <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_row   <= r_row + CNT_W'(1);
                        r_issue <= '0;
                        r_sum   <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_SWEEP: begin
                    // Find the farthest kept distance again, one slot a cycle.
                    r_max <= n_max;
                    if (r_slot == r_fill - K_W'(1)) begin
                        r_far  <= n_max;
                        r_slot <= '0;
                        if (row_end) begin
                            r_svd   <= '0;
                            r_sd    <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_row   <= r_row + CNT_W'(1);
                            r_issue <= '0;
                            r_sum   <= '0;
                            r_state <= S_ACC;
                        end
                    end else begin
                        r_slot <= r_slot + K_W'(1);
                    end
                end
                S_SUM: begin
                    if (sum_done) begin
                        if (r_sd == '0) begin
                            r_res_est    <= '0;
                            r_res_status <= ST_ZERO;
                            r_state      <= S_DONE;
                        end else begin
                            r_neg   <= r_svd[DIV_W-1];
                            r_state <= S_FDIV;
                        end
                    end
                end
                S_FDIV: begin
                    if (div_done) begin
                        r_res_est    <= est_sat;
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_res_ch.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_est    <= r_res_est;
                        r_out_status <= r_res_status;
                        r_out_rows   <= r_job.rows;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_ch.valid       = r_out_valid;
    assign o_res_ch.estimate    = r_out_est;
    assign o_res_ch.status      = r_out_status;
    assign o_res_ch.stored_rows = r_out_rows;

`ifndef SYNTHESIS
    // Never more neighbours kept than asked for.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_fill <= r_job.k))
        else $error("neighbour fill exceeds k");

    // A replacement sweep only happens with every slot in use.
    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_fill == r_job.k))
        else $error("sweep with partly filled slots");

    // The scan never runs past the stored rows.
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_row < r_job.rows))
        else $error("row index beyond table");

    // A result with a bad status carries a zero estimate.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && o_res_ch.status != ST_OK) |-> (o_res_ch.estimate == '0))
        else $error("nonzero estimate with error status");
`endif
endmodule

@@ design/knn_weighted_value_estimator_core.sv @@
// Distance-weighted k-nearest-neighbor estimator. Attribute items are
// transferred one per cycle; a training row that ends before the full row
// width holds the input while its unused attribute slots are zeroed, and a
// clear waits until no query is pending. At a query row end the query is
// handed to a two-entry job queue, so the next rows can be taken while the
// scan runs. The scan visits stored rows one at a time: it reads and
// accumulates A attributes from the feature memory, takes their mean in the
// shared bit-serial divider and the square root of it in root-mean-square
// mode, then updates the kept neighbors and sweeps the kept slots again when
// a farther neighbor is replaced. The final weighted sum is divided in the
// same divider, then the result waits in an output register until
// transferred.
module knn_weighted_value_estimator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    kwve_in_if.sink                         i_req_ch,
    kwve_out_if.source                      o_res_ch,
    input  logic                            i_cfg_we,
    input  logic [kwve_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kwve_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kwve_pkg::*;

    logic               feat_we;
    logic [FADDR_W-1:0] feat_waddr;
    logic [FEAT_W-1:0]  feat_wdata;
    logic [FADDR_W-1:0] feat_raddr;
    logic [FEAT_W-1:0]  feat_rdata;
    logic               val_we;
    logic [ROW_W-1:0]   val_waddr;
    logic [VAL_W-1:0]   val_wdata;
    logic [ROW_W-1:0]   val_raddr;
    logic [VAL_W-1:0]   val_rdata;
    logic               job_valid;
    t_job               job;
    logic               job_pop;
    logic               back_idle;

    kwve_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_ch     (i_req_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_feat_we    (feat_we),
        .o_feat_waddr (feat_waddr),
        .o_feat_wdata (feat_wdata),
        .o_val_we     (val_we),
        .o_val_waddr  (val_waddr),
        .o_val_wdata  (val_wdata),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_pop    (job_pop),
        .i_back_idle  (back_idle)
    );

    // Feature table, one row of MAX_ATTRS entries per stored row.
    kwve_ram #(
        .WIDTH (FEAT_W),
        .DEPTH (MAX_ROWS * MAX_ATTRS)
    ) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (feat_we),
        .i_waddr (feat_waddr),
        .i_wdata (feat_wdata),
        .i_raddr (feat_raddr),
        .o_rdata (feat_rdata)
    );

    // Known value of each stored row.
    kwve_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ROWS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    kwve_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_pop    (job_pop),
        .o_idle       (back_idle),
        .o_feat_raddr (feat_raddr),
        .i_feat_rdata (feat_rdata),
        .o_val_raddr  (val_raddr),
        .i_val_rdata  (val_rdata),
        .o_res_ch     (o_res_ch)
    );
endmodule
